// File: rtl/core/tdpt_pkg.sv
`default_nettype none

package tdpt_pkg;

    localparam int unsigned VALUE_W = 31;
    localparam int unsigned DIV_W   = 16;
    localparam int unsigned SQ_W    = 32;
    localparam int unsigned STEP_W  = $clog2(VALUE_W);

    localparam logic [DIV_W-1:0] FIRST_DIVISOR = DIV_W'(2);
    localparam logic [SQ_W-1:0]  FIRST_SQUARE  = SQ_W'(4);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_DIVIDE,
        ST_DONE
    } tdpt_state_t;

    typedef struct packed {
        logic               start;
        logic [VALUE_W-1:0] dividend;
        logic [DIV_W-1:0]   divisor;
    } tdpt_rem_req_t;

    typedef struct packed {
        logic done;
        logic zero;
    } tdpt_rem_rsp_t;

    typedef struct packed {
        logic busy;
        logic done;
        logic flag;
    } tdpt_status_t;

endpackage

`default_nettype wire

// File: rtl/core/trial_division_prime_test.sv
`default_nettype none

// Trial-division primality test. Each accepted transaction on the number channel carries one
// signed 32-bit value and produces exactly one transaction on the result channel, whose
// prime_flag is 1 when the value is prime. Negative values, zero and one go straight to the
// done state with no trial division. Otherwise divisors 2, 3, 4 and so on are tried while their
// square does not exceed the value, each trial running one 31-step restoring remainder
// calculation in a shared unit. One value is worked on at a time and number_stall stays high
// meanwhile. A finished result waits in an output register, so a new value can be taken
// while the previous result is still stalled.
module trial_division_prime_test
    import tdpt_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        number_valid,
    output logic             number_stall,
    input  wire logic [31:0] number,
    output logic             result_valid,
    input  wire logic        result_stall,
    output logic             prime_flag
);

    tdpt_rem_req_t rem_req;
    tdpt_rem_rsp_t rem_rsp;
    tdpt_status_t  status;
    logic          res_ready;
    logic          out_valid_reg;
    logic          out_valid_next;
    logic          out_flag_reg;
    logic          out_flag_next;

    assign res_ready = !out_valid_reg || !result_stall;

    tdpt_ctrl u_ctrl
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number       (number),
        .res_ready    (res_ready),
        .rem_rsp      (rem_rsp),
        .rem_req      (rem_req),
        .status       (status)
    );

    tdpt_rem_unit u_rem_unit
    (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (rem_req),
        .rsp   (rem_rsp)
    );

    always_comb
    begin
        out_valid_next = out_valid_reg;
        out_flag_next  = out_flag_reg;
        if (out_valid_reg && !result_stall)
        begin
            out_valid_next = 1'b0;
        end
        if (status.done && res_ready)
        begin
            out_valid_next = 1'b1;
            out_flag_next  = status.flag;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_flag_reg <= out_flag_next;
    end

    assign number_stall = status.busy;
    assign result_valid = out_valid_reg;
    assign prime_flag   = out_flag_reg;

endmodule

`default_nettype wire

// File: rtl/core/tdpt_rem_unit.sv
`default_nettype none

module tdpt_rem_unit
    import tdpt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire tdpt_rem_req_t req,
    output tdpt_rem_rsp_t      rsp
);

    logic              busy_reg;
    logic              busy_next;
    logic              done_reg;
    logic              done_next;
    logic [STEP_W-1:0] cnt_reg;
    logic [STEP_W-1:0] cnt_next;
    logic [VALUE_W-1:0] dividend_reg;
    logic [VALUE_W-1:0] dividend_next;
    logic [DIV_W-1:0]  divisor_reg;
    logic [DIV_W-1:0]  divisor_next;
    logic [DIV_W-1:0]  rem_reg;
    logic [DIV_W-1:0]  rem_next;
    logic [DIV_W:0]    trial;
    logic [DIV_W:0]    diff;
    logic              last_step;

    // One restoring step per cycle: shift in the next dividend bit and subtract if it fits.
    assign trial     = {rem_reg, dividend_reg[VALUE_W-1]};
    assign diff      = trial - {1'b0, divisor_reg};
    assign last_step = (cnt_reg == STEP_W'(VALUE_W - 1));

    always_comb
    begin
        busy_next     = busy_reg;
        done_next     = 1'b0;
        cnt_next      = cnt_reg;
        dividend_next = dividend_reg;
        divisor_next  = divisor_reg;
        rem_next      = rem_reg;
        if (req.start && !busy_reg)
        begin
            busy_next     = 1'b1;
            cnt_next      = '0;
            dividend_next = req.dividend;
            divisor_next  = req.divisor;
            rem_next      = '0;
        end
        else if (busy_reg)
        begin
            dividend_next = {dividend_reg[VALUE_W-2:0], 1'b0};
            if (trial >= {1'b0, divisor_reg})
            begin
                rem_next = diff[DIV_W-1:0];
            end
            else
            begin
                rem_next = trial[DIV_W-1:0];
            end
            cnt_next = cnt_reg + STEP_W'(1);
            if (last_step)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        dividend_reg <= dividend_next;
        divisor_reg  <= divisor_next;
        rem_reg      <= rem_next;
    end

    assign rsp.done = done_reg;
    assign rsp.zero = (rem_reg == '0);

    a_no_start_when_busy: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start)
        else $error("Remainder unit started while busy.");

    a_rem_below_divisor: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && cnt_reg != '0) |-> (rem_reg < divisor_reg))
        else $error("Partial remainder not below the divisor.");

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg))
        else $error("Remainder unit finished without working.");

endmodule

`default_nettype wire

// File: rtl/core/tdpt_ctrl.sv
`default_nettype none

module tdpt_ctrl
    import tdpt_pkg::*;
(
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          number_valid,
    input  wire logic [31:0]   number,
    input  wire logic          res_ready,
    input  wire tdpt_rem_rsp_t rem_rsp,
    output tdpt_rem_req_t      rem_req,
    output tdpt_status_t       status
);

    tdpt_state_t        state_reg;
    tdpt_state_t        state_next;
    logic [VALUE_W-1:0] value_reg;
    logic [VALUE_W-1:0] value_next;
    logic [DIV_W-1:0]   d_reg;
    logic [DIV_W-1:0]   d_next;
    logic [SQ_W-1:0]    sq_reg;
    logic [SQ_W-1:0]    sq_next;
    logic               flag_reg;
    logic               flag_next;
    logic               trivial;
    logic               start;

    // Negative values, zero and one are never prime.
    assign trivial = number[31] || (number[30:1] == '0);

    always_comb
    begin
        state_next = state_reg;
        value_next = value_reg;
        d_next     = d_reg;
        sq_next    = sq_reg;
        flag_next  = flag_reg;
        start      = 1'b0;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (number_valid)
                begin
                    value_next = number[VALUE_W-1:0];
                    d_next     = FIRST_DIVISOR;
                    sq_next    = FIRST_SQUARE;
                    flag_next  = 1'b0;
                    state_next = trivial ? ST_DONE : ST_CHECK;
                end
            end
            ST_CHECK:
            begin
                if (sq_reg > {1'b0, value_reg})
                begin
                    flag_next  = 1'b1;
                    state_next = ST_DONE;
                end
                else
                begin
                    start      = 1'b1;
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (rem_rsp.done)
                begin
                    if (rem_rsp.zero)
                    begin
                        flag_next  = 1'b0;
                        state_next = ST_DONE;
                    end
                    else
                    begin
                        // The next square follows from (d + 1)^2 = d^2 + 2d + 1.
                        sq_next    = sq_reg + SQ_W'({d_reg, 1'b1});
                        d_next     = d_reg + DIV_W'(1);
                        state_next = ST_CHECK;
                    end
                end
            end
            ST_DONE:
            begin
                if (res_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
        d_reg     <= d_next;
        sq_reg    <= sq_next;
        flag_reg  <= flag_next;
    end

    assign rem_req.start    = start;
    assign rem_req.dividend = value_reg;
    assign rem_req.divisor  = d_reg;

    assign status.busy = (state_reg != ST_IDLE);
    assign status.done = (state_reg == ST_DONE);
    assign status.flag = flag_reg;

    a_rem_done_in_divide: assert property (@(posedge clk) disable iff (!rst_n)
        rem_rsp.done |-> (state_reg == ST_DIVIDE))
        else $error("Remainder returned outside the divide state.");

    a_divisor_at_least_two: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_CHECK || state_reg == ST_DIVIDE) |-> (d_reg >= FIRST_DIVISOR))
        else $error("Trial divisor below two.");

    a_trivial_goes_done: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_IDLE && number_valid && trivial) |=> (state_reg == ST_DONE && !flag_reg))
        else $error("Value of one or less not answered at once.");

endmodule

`default_nettype wire

// File: test/tb_top.sv
`timescale 1ns / 100ps

module tb_top;

    localparam int unsigned IDLE_LIMIT   = 8_000_000;
    localparam int unsigned DRAIN_CYCLES = 100;

    logic        clk          = 1'b0;
    logic        rst_n        = 1'b0;
    logic        number_valid = 1'b0;
    logic [31:0] number       = 32'd0;
    logic        result_stall = 1'b0;
    logic        number_stall;
    logic        result_valid;
    logic        prime_flag;

    logic        no_gaps = 1'b0;
    logic        pending_prime_flags[$];
    int unsigned mismatch_count = 0;
    int unsigned idle_cycles = 0;

    trial_division_prime_test dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .number_valid (number_valid),
        .number_stall (number_stall),
        .number       (number),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .prime_flag   (prime_flag)
    );

    always #2 clk = ~clk;

    function automatic logic prime_by_trial(input logic [31:0] value);
        logic [63:0] divisor;
        if (value[31])
        begin
            return 1'b0;
        end
        if (value <= 32'd1)
        begin
            return 1'b0;
        end
        for (divisor = 64'd2; divisor * divisor <= {32'd0, value}; divisor++)
        begin
            if ({32'd0, value} % divisor == 64'd0)
            begin
                return 1'b0;
            end
        end
        return 1'b1;
    endfunction

    // The valid is left high on return, so a following transaction with no gap keeps it high.
    task automatic send_number(input logic [31:0] value);
        int unsigned gap;
        gap = no_gaps ? 0 : $urandom_range(0, 15);
        if (gap != 0)
        begin
            number_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        number       <= value;
        number_valid <= 1'b1;
        do
        begin
            @(posedge clk);
        end
        while (number_stall);
        pending_prime_flags.push_back(prime_by_trial(value));
    endtask

    task automatic wait_for_results();
        number_valid <= 1'b0;
        while (pending_prime_flags.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    always
    begin
        int unsigned hold;
        hold = no_gaps ? 0 : $urandom_range(0, 15);
        if (hold != 0)
        begin
            result_stall <= 1'b1;
            repeat (hold) @(posedge clk);
        end
        result_stall <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (!result_valid);
    end

    always @(posedge clk)
    begin
        logic expected_flag;
        if (result_valid && !result_stall)
        begin
            if (pending_prime_flags.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual prime_flag %0b",
                         $time, prime_flag);
                mismatch_count++;
            end
            else
            begin
                expected_flag = pending_prime_flags.pop_front();
                if (prime_flag !== expected_flag)
                begin
                    $display("%0t: prime_flag mismatch, expected %0b, actual %0b",
                             $time, expected_flag, prime_flag);
                    mismatch_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        if ((number_valid && !number_stall) || (result_valid && !result_stall))
        begin
            idle_cycles <= 0;
        end
        else if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("trial_division_prime_test verification failed");
            $finish;
        end
        else
        begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    task automatic test_negative_values();
        send_number(32'h8000_0000);
        send_number(32'hFFFF_FFFF);
        send_number(32'hFFFF_FFFE);
        send_number(-32'sd7);
        send_number(32'hC000_0001);
    endtask

    task automatic test_zero_and_one();
        send_number(32'd0);
        send_number(32'd1);
    endtask

    task automatic test_small_values();
        send_number(32'd2);
        send_number(32'd3);
        send_number(32'd4);
        send_number(32'd5);
        send_number(32'd9);
        send_number(32'd25);
        send_number(32'd49);
    endtask

    task automatic test_larger_values();
        send_number(32'd65521);
        send_number(32'd65537);
        send_number(32'd1048573);
        send_number(32'd1052651);
    endtask

    task automatic test_positive_extremes();
        send_number(32'h7FFF_FFFF);
        send_number(32'h7FFF_FFFE);
        send_number(32'h7FFF_FFFD);
    endtask

    task automatic test_pause_until_drained();
        send_number(32'd97);
        send_number(32'd91);
        wait_for_results();
        send_number(32'd101);
        send_number(32'd4096);
    endtask

    task automatic test_random_values();
        logic [31:0] value;
        logic [31:0] factor;
        for (int i = 0; i < 75; i++)
        begin
            no_gaps = ((i / 20) % 3) == 1;
            case ($urandom_range(0, 19))
                0, 1, 2, 3:
                begin
                    value = $urandom() | 32'h8000_0000;
                end
                4, 5, 6, 7, 8, 9, 10, 11, 12, 13:
                begin
                    value = $urandom_range(0, 4095);
                end
                14, 15, 16:
                begin
                    value = $urandom_range(4096, 1 << 20);
                end
                17, 18:
                begin
                    value = $urandom() & 32'h7FFF_FFFE;
                end
                default:
                begin
                    factor = $urandom_range(1, 5) * 2 + 1;
                    value  = factor * $urandom_range(1, 32'h7FFF_FFFF / factor);
                end
            endcase
            send_number(value);
        end
        no_gaps = 1'b0;
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_negative_values();
        test_zero_and_one();
        test_small_values();
        test_larger_values();
        test_positive_extremes();
        test_pause_until_drained();
        test_random_values();
        wait_for_results();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_prime_flags.size() == 0)
        begin
            $display("trial_division_prime_test verification clean");
        end
        else
        begin
            $display("trial_division_prime_test verification failed");
        end
        $finish;
    end

endmodule
